// ===== src/fvt_pkg.sv =====
// ----------------------------------------------------------------------------
// fvt_pkg
// Shared types and constants for the frustum visibility test: shape codes,
// coefficient and extent widths, and the register map of the plane port.
// ----------------------------------------------------------------------------
package fvt_pkg;

  typedef enum logic [1:0] {
    OP_POINT  = 2'd0,
    OP_SPHERE = 2'd1,
    OP_CUBE   = 2'd2,
    OP_BOX    = 2'd3
  } op_e;

  localparam int unsigned CoefWidth   = 16;
  localparam int unsigned ExtWidth    = 15;
  localparam int unsigned AbsWidth    = CoefWidth + 1;
  localparam int unsigned BoundWidth  = AbsWidth + ExtWidth;
  localparam int unsigned FracBits    = 8;
  localparam int unsigned CfgCount    = 6;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned CfgAddrW    = 6;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgIdxLsb   = 3;

  typedef logic [CfgDataW-1:0] plane_t;

endpackage

// ===== src/fvt_if.sv =====
// ----------------------------------------------------------------------------
// fvt_query_if / fvt_result_if
// Valid/ready channels for culling queries and visibility results.
// ----------------------------------------------------------------------------
interface fvt_query_if
  import fvt_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  op_e                          operation;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic signed [COORD_WIDTH-1:0] center_z;
  logic        [ExtWidth-1:0]   extent_x;
  logic        [ExtWidth-1:0]   extent_y;
  logic        [ExtWidth-1:0]   extent_z;

  modport source (
    output valid, operation, center_x, center_y, center_z,
           extent_x, extent_y, extent_z,
    input  ready
  );
  modport sink (
    input  valid, operation, center_x, center_y, center_z,
           extent_x, extent_y, extent_z,
    output ready
  );
endinterface

interface fvt_result_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

// ===== src/frustum_visibility_test.sv =====
// ----------------------------------------------------------------------------
// frustum_visibility_test
// Six-plane view frustum culling of points, spheres, cubes and boxes.
//
//   channel   dir   handshake        payload
//   query_i   in    valid/ready      operation, center_x/y/z, extent_x/y/z
//   result_o  out   valid/ready      visible
//   apb       in    psel/penable     plane_0..plane_5 at 8*i, 64-bit data
//
// one query per cycle while the output is not stalled; each query passes through the
// input register, product register (multiplier bank), result register
// each stage holds on its own, so bubbles close up under an output stall
// reset clears the planes to zero and all stage valid flags
// ----------------------------------------------------------------------------
module frustum_visibility_test
  import fvt_pkg::*;
#(
  parameter int unsigned NUM_PLANES  = 6,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  fvt_query_if.sink           query_i,
  fvt_result_if.source        result_o
);

  localparam int unsigned ProdW = CoefWidth + COORD_WIDTH;
  localparam int unsigned TermW = (ProdW > BoundWidth + 1) ? ProdW : BoundWidth + 1;
  localparam int unsigned SumW  = TermW + 3;
  localparam int unsigned DW    = CoefWidth + FracBits;

  // plane registers
  plane_t               plane_q [NUM_PLANES];
  logic                 cfg_wr;
  logic [CfgIdxW-1:0]   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[CfgIdxLsb +: CfgIdxW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PLANES; i++) plane_q[i] <= '0;
    end else if (cfg_wr) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        if (i < CfgCount && cfg_idx == CfgIdxW'(i)) plane_q[i] <= pwdata;
      end
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < NUM_PLANES; i++) begin
      if (i < CfgCount && cfg_idx == CfgIdxW'(i)) prdata = plane_q[i];
    end
  end

  // stage handshake
  logic s1_valid_q, s2_valid_q, res_valid_q;
  logic s1_ready, s2_ready, res_ready;

  assign res_ready     = !res_valid_q || result_o.ready;
  assign s2_ready      = !s2_valid_q || res_ready;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign query_i.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid_q  <= query_i.valid;
      if (s2_ready)  s2_valid_q  <= s1_valid_q;
      if (res_ready) res_valid_q <= s2_valid_q;
    end
  end

  // stage 1: input register
  op_e                           op_q;
  logic signed [COORD_WIDTH-1:0] cx_q, cy_q, cz_q;
  logic        [ExtWidth-1:0]    ex_q, ey_q, ez_q;

  always_ff @(posedge clk_i) begin
    if (s1_ready && query_i.valid) begin
      op_q <= query_i.operation;
      cx_q <= query_i.center_x;
      cy_q <= query_i.center_y;
      cz_q <= query_i.center_z;
      ex_q <= query_i.extent_x;
      ey_q <= (query_i.operation == OP_CUBE) ? query_i.extent_x : query_i.extent_y;
      ez_q <= (query_i.operation == OP_CUBE) ? query_i.extent_x : query_i.extent_z;
    end
  end

  // stage 2: per-plane products and extent bounds
  logic signed [ProdW-1:0]      px_d [NUM_PLANES];
  logic signed [ProdW-1:0]      py_d [NUM_PLANES];
  logic signed [ProdW-1:0]      pz_d [NUM_PLANES];
  logic        [BoundWidth-1:0] bx_d [NUM_PLANES];
  logic        [BoundWidth-1:0] by_d [NUM_PLANES];
  logic        [BoundWidth-1:0] bz_d [NUM_PLANES];
  logic signed [ProdW-1:0]      px_q [NUM_PLANES];
  logic signed [ProdW-1:0]      py_q [NUM_PLANES];
  logic signed [ProdW-1:0]      pz_q [NUM_PLANES];
  logic        [BoundWidth-1:0] bx_q [NUM_PLANES];
  logic        [BoundWidth-1:0] by_q [NUM_PLANES];
  logic        [BoundWidth-1:0] bz_q [NUM_PLANES];

  always_comb begin
    logic signed [CoefWidth-1:0] ca, cb, cc;
    logic        [AbsWidth-1:0]  aa, ab, ac;
    for (int i = 0; i < NUM_PLANES; i++) begin
      ca = $signed(plane_q[i][63:48]);
      cb = $signed(plane_q[i][47:32]);
      cc = $signed(plane_q[i][31:16]);
      aa = ca[CoefWidth-1] ? AbsWidth'(-$signed({ca[CoefWidth-1], ca}))
                           : AbsWidth'({1'b0, ca});
      ab = cb[CoefWidth-1] ? AbsWidth'(-$signed({cb[CoefWidth-1], cb}))
                           : AbsWidth'({1'b0, cb});
      ac = cc[CoefWidth-1] ? AbsWidth'(-$signed({cc[CoefWidth-1], cc}))
                           : AbsWidth'({1'b0, cc});
      px_d[i] = ProdW'(ca) * ProdW'(cx_q);
      py_d[i] = ProdW'(cb) * ProdW'(cy_q);
      pz_d[i] = ProdW'(cc) * ProdW'(cz_q);
      case (op_q)
        OP_POINT: begin
          bx_d[i] = '0;
          by_d[i] = '0;
          bz_d[i] = '0;
        end
        OP_SPHERE: begin
          bx_d[i] = BoundWidth'({ex_q, {FracBits{1'b0}}});
          by_d[i] = '0;
          bz_d[i] = '0;
        end
        default: begin
          bx_d[i] = BoundWidth'(aa) * BoundWidth'(ex_q);
          by_d[i] = BoundWidth'(ab) * BoundWidth'(ey_q);
          bz_d[i] = BoundWidth'(ac) * BoundWidth'(ez_q);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        px_q[i] <= px_d[i];
        py_q[i] <= py_d[i];
        pz_q[i] <= pz_d[i];
        bx_q[i] <= bx_d[i];
        by_q[i] <= by_d[i];
        bz_q[i] <= bz_d[i];
      end
    end
  end

  // stage 3: plane distance plus extent bound (farthest corner for cubes and boxes), culled when negative
  logic visible_d, visible_q;

  always_comb begin
    logic signed [DW-1:0]   dterm;
    logic signed [SumW-1:0] sum;
    visible_d = 1'b1;
    for (int i = 0; i < NUM_PLANES; i++) begin
      dterm = $signed({plane_q[i][15:0], {FracBits{1'b0}}});
      sum   = SumW'(px_q[i]) + SumW'(py_q[i]) + SumW'(pz_q[i]) + SumW'(dterm)
            + $signed(SumW'(bx_q[i])) + $signed(SumW'(by_q[i]))
            + $signed(SumW'(bz_q[i]));
      if (sum[SumW-1]) visible_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && s2_valid_q) visible_q <= visible_d;
  end

  assign result_o.valid   = res_valid_q;
  assign result_o.visible = visible_q;

  // checks
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_q |-> query_i.ready)
    else $error("query stalled with empty output stage");

  a_result_from_s2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(s2_valid_q))
    else $error("result appeared without a product stage item");

  a_s1_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_ready) |=> s2_valid_q)
    else $error("stage 1 item lost");

  a_plane0_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && cfg_idx == '0) |=> plane_q[0] == $past(pwdata))
    else $error("plane 0 write not taken");

endmodule
